[hw/rtl/hsd_pkg.sv]
// Shared types and constants for the Huffman stream decoder.
`timescale 1ns / 1ps

package hsd_pkg;

    // Stream parsing phase.
    typedef enum logic [2:0] {
        PH_SIZE,
        PH_COUNT,
        PH_SYM,
        PH_LEN,
        PH_CODE,
        PH_DECODE,
        PH_HALT
    } phase_t;

    // Bit sequencer state.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_RD,
        ST_WSYM,
        ST_FLUSH
    } seq_state_t;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 64;
    localparam int LEN_W       = 9;
    localparam int HDR_LAST    = 7;
    localparam logic [LEN_W-1:0] FULL_LEN = 9'd256;

endpackage

[hw/rtl/hsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/huffman_stream_decoder_top.sv]
// Huffman stream decoder: header parser, node table builder and code walker.
//
// Usage: compressed bytes enter on the s_ side, one byte per word, bits used
// most significant first. The first eight bytes give the symbol count
// (little endian), the ninth the number of table entries (0 means 256).
// Entries follow as bit-aligned symbol and length fields plus code bits,
// which build the node table. Then the code bits are walked from the root
// and every leaf reached gives one word on the m_ side. tlast marks the
// final word caused by one input byte; tuser holds finished and error.
// Header bytes are taken in the idle state alone. A byte of table or code
// bits is accepted, then each bit is gathered or allocates a new node; a
// bit that follows an existing node first reads the node table (registered
// read data), and one that ends a code on a new node then writes its symbol;
// last the byte is closed. The byte takes longer while the m_ side stalls.
// The table is in a single RAM; no clearing pass is needed, since every
// allocated node is written before it is read and the root is cached in a
// register.
// Reset returns to the size header and drops pending output. When the m_
// side stalls, the sequencer holds in place until the output word moves.
`timescale 1ns / 1ps

module huffman_stream_decoder_top #(
    parameter int NODE_COUNT = 512
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] symbol_byte
    output logic       m_tlast,   // last_of_run
    output logic [1:0] m_tuser    // [0] finished, [1] error
);

    import hsd_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);
    localparam int NW = AW + 1;
    localparam int EW = 2 * AW + BYTE_W;
    localparam int L_HI = EW - 1;
    localparam int R_HI = EW - 1 - AW;
    localparam logic [NW-1:0] NODE_LIMIT = NW'(NODE_COUNT);

    // Registers.
    seq_state_t          state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [2:0]          hdr_idx_reg, hdr_idx_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]    entries_reg, entries_next;
    logic [BYTE_W-1:0]   gbits_reg, gbits_next;
    logic [2:0]          gcnt_reg, gcnt_next;
    logic [BYTE_W-1:0]   esym_reg, esym_next;
    logic [LEN_W-1:0]    cbl_reg, cbl_next;
    logic [AW-1:0]       walk_reg, walk_next;
    logic [NW-1:0]       nf_reg, nf_next;
    logic [EW-1:0]       cur_reg, cur_next;
    logic [EW-1:0]       root_reg, root_next;
    logic [AW-1:0]       child_reg, child_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic [2:0]          bcnt_reg, bcnt_next;
    logic                pend_v_reg, pend_v_next;
    logic [BYTE_W-1:0]   pend_sym_reg, pend_sym_next;
    logic                pend_fin_reg, pend_fin_next;
    logic                pend_err_reg, pend_err_next;
    logic                out_v_reg, out_v_next;
    logic [BYTE_W-1:0]   out_sym_reg, out_sym_next;
    logic                out_last_reg, out_last_next;
    logic                out_fin_reg, out_fin_next;
    logic                out_err_reg, out_err_next;

    // Node table RAM.
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [EW-1:0]       mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [EW-1:0]       mem_rdata;

    hsd_ram #(
        .WIDTH (EW),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Helper signals.
    logic              cur_bit;
    logic [AW-1:0]     cur_child;
    logic [AW-1:0]     rd_left;
    logic [AW-1:0]     rd_right;
    logic              out_free;
    logic              move_ok;
    logic              emit;
    logic [BYTE_W-1:0] e_sym;
    logic              e_fin;
    logic              e_err;
    logic              flush;
    logic              adv;

    assign cur_bit   = shift_reg[BYTE_W-1];
    assign cur_child = cur_bit ? cur_reg[R_HI -: AW] : cur_reg[L_HI -: AW];
    assign rd_left   = mem_rdata[L_HI -: AW];
    assign rd_right  = mem_rdata[R_HI -: AW];
    assign out_free  = !out_v_reg || m_tready;
    assign move_ok   = !pend_v_reg || out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_err_reg, out_fin_reg};

    // Sequencer: next state, table access and result generation.
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        rem_next     = rem_reg;
        entries_next = entries_reg;
        gbits_next   = gbits_reg;
        gcnt_next    = gcnt_reg;
        esym_next    = esym_reg;
        cbl_next     = cbl_reg;
        walk_next    = walk_reg;
        nf_next      = nf_reg;
        cur_next     = cur_reg;
        child_next   = child_reg;
        shift_next   = shift_reg;
        bcnt_next    = bcnt_reg;
        mem_we       = 1'b0;
        mem_waddr    = walk_reg;
        mem_wdata    = cur_reg;
        mem_raddr    = child_reg;
        emit         = 1'b0;
        e_sym        = '0;
        e_fin        = 1'b0;
        e_err        = 1'b0;
        flush        = 1'b0;
        adv          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (phase_reg)
                        PH_SIZE:
                        begin
                            rem_next = rem_reg
                                | (COUNT_W'(s_tdata) << {hdr_idx_reg, 3'b000});
                            if (hdr_idx_reg == 3'(HDR_LAST))
                            begin
                                hdr_idx_next = '0;
                                phase_next   = PH_COUNT;
                            end
                            else
                            begin
                                hdr_idx_next = hdr_idx_reg + 3'd1;
                            end
                        end
                        PH_COUNT:
                        begin
                            entries_next = (s_tdata != '0) ? LEN_W'(s_tdata) : FULL_LEN;
                            gbits_next   = '0;
                            gcnt_next    = '0;
                            phase_next   = PH_SYM;
                        end
                        PH_HALT:
                        begin
                            phase_next = PH_HALT;
                        end
                        default:
                        begin
                            shift_next = s_tdata;
                            bcnt_next  = '0;
                            state_next = ST_BIT;
                        end
                    endcase
                end
            end

            ST_BIT:
            begin
                case (phase_reg)
                    PH_SYM, PH_LEN:
                    begin
                        adv = 1'b1;
                        if (gcnt_reg == 3'd7)
                        begin
                            gbits_next = '0;
                            gcnt_next  = '0;
                            if (phase_reg == PH_SYM)
                            begin
                                esym_next  = {gbits_reg[6:0], cur_bit};
                                phase_next = PH_LEN;
                            end
                            else
                            begin
                                cbl_next   = ({gbits_reg[6:0], cur_bit} != '0)
                                    ? LEN_W'({gbits_reg[6:0], cur_bit}) : FULL_LEN;
                                walk_next  = '0;
                                cur_next   = root_reg;
                                phase_next = PH_CODE;
                            end
                        end
                        else
                        begin
                            gbits_next = {gbits_reg[6:0], cur_bit};
                            gcnt_next  = gcnt_reg + 3'd1;
                        end
                    end
                    PH_CODE:
                    begin
                        if (cur_child != '0)
                        begin
                            mem_raddr  = cur_child;
                            child_next = cur_child;
                            state_next = ST_RD;
                        end
                        else if (nf_reg >= NODE_LIMIT)
                        begin
                            if (move_ok)
                            begin
                                emit       = 1'b1;
                                e_err      = 1'b1;
                                phase_next = PH_HALT;
                                state_next = ST_FLUSH;
                            end
                        end
                        else
                        begin
                            // Allocate a new child and link it into the parent.
                            mem_we    = 1'b1;
                            mem_waddr = walk_reg;
                            mem_wdata = cur_reg;
                            if (cur_bit)
                            begin
                                mem_wdata[R_HI -: AW] = nf_reg[AW-1:0];
                            end
                            else
                            begin
                                mem_wdata[L_HI -: AW] = nf_reg[AW-1:0];
                            end
                            nf_next    = nf_reg + NW'(1);
                            child_next = nf_reg[AW-1:0];
                            cbl_next   = cbl_reg - LEN_W'(1);
                            if (cbl_reg == LEN_W'(1))
                            begin
                                // Code ends on the new node: store its symbol next.
                                walk_next    = '0;
                                entries_next = entries_reg - LEN_W'(1);
                                if (entries_reg == LEN_W'(1))
                                begin
                                    phase_next = (rem_reg == '0) ? PH_HALT : PH_DECODE;
                                end
                                else
                                begin
                                    phase_next = PH_SYM;
                                end
                                state_next = ST_WSYM;
                            end
                            else
                            begin
                                walk_next = nf_reg[AW-1:0];
                                cur_next  = '0;
                                adv       = 1'b1;
                            end
                        end
                    end
                    PH_DECODE:
                    begin
                        if (cur_child != '0)
                        begin
                            mem_raddr  = cur_child;
                            child_next = cur_child;
                            state_next = ST_RD;
                        end
                        else if (move_ok)
                        begin
                            emit       = 1'b1;
                            e_err      = 1'b1;
                            phase_next = PH_HALT;
                            state_next = ST_FLUSH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FLUSH;
                    end
                endcase
            end

            ST_RD:
            begin
                // Keep the address so the read data holds through a stall.
                mem_raddr = child_reg;
                if (phase_reg == PH_CODE)
                begin
                    cbl_next = cbl_reg - LEN_W'(1);
                    adv      = 1'b1;
                    if (cbl_reg == LEN_W'(1))
                    begin
                        mem_we       = 1'b1;
                        mem_waddr    = child_reg;
                        mem_wdata    = {mem_rdata[L_HI -: 2 * AW], esym_reg};
                        walk_next    = '0;
                        cur_next     = root_reg;
                        entries_next = entries_reg - LEN_W'(1);
                        if (entries_reg == LEN_W'(1))
                        begin
                            phase_next = (rem_reg == '0) ? PH_HALT : PH_DECODE;
                        end
                        else
                        begin
                            phase_next = PH_SYM;
                        end
                    end
                    else
                    begin
                        walk_next = child_reg;
                        cur_next  = mem_rdata;
                    end
                end
                else if (rd_left == '0 && rd_right == '0)
                begin
                    // Leaf reached: emit its symbol and restart at the root.
                    if (move_ok)
                    begin
                        emit      = 1'b1;
                        e_sym     = mem_rdata[BYTE_W-1:0];
                        e_fin     = (rem_reg == COUNT_W'(1));
                        rem_next  = rem_reg - COUNT_W'(1);
                        walk_next = '0;
                        cur_next  = root_reg;
                        adv       = 1'b1;
                        if (rem_reg == COUNT_W'(1))
                        begin
                            phase_next = PH_HALT;
                        end
                    end
                end
                else
                begin
                    walk_next = child_reg;
                    cur_next  = mem_rdata;
                    adv       = 1'b1;
                end
            end

            ST_WSYM:
            begin
                mem_we    = 1'b1;
                mem_waddr = child_reg;
                mem_wdata = {{(2 * AW){1'b0}}, esym_reg};
                cur_next  = root_reg;
                adv       = 1'b1;
            end

            ST_FLUSH:
            begin
                if (!pend_v_reg || out_free)
                begin
                    flush      = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Step to the next bit, or close the byte.
        if (adv)
        begin
            shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
            bcnt_next  = bcnt_reg + 3'd1;
            if (bcnt_reg == 3'd7 || phase_next == PH_HALT)
            begin
                state_next = ST_FLUSH;
            end
            else
            begin
                state_next = ST_BIT;
            end
        end
    end

    // Root cache follows every write to node zero.
    assign root_next = (mem_we && mem_waddr == '0) ? mem_wdata : root_reg;

    // Result staging: the newest result waits until its tlast is known.
    always_comb
    begin
        out_v_next    = out_v_reg && !m_tready;
        out_sym_next  = out_sym_reg;
        out_last_next = out_last_reg;
        out_fin_next  = out_fin_reg;
        out_err_next  = out_err_reg;
        pend_v_next   = pend_v_reg;
        pend_sym_next = pend_sym_reg;
        pend_fin_next = pend_fin_reg;
        pend_err_next = pend_err_reg;
        if ((emit || flush) && pend_v_reg)
        begin
            out_v_next    = 1'b1;
            out_sym_next  = pend_sym_reg;
            out_last_next = flush;
            out_fin_next  = pend_fin_reg;
            out_err_next  = pend_err_reg;
            pend_v_next   = 1'b0;
        end
        if (emit)
        begin
            pend_v_next   = 1'b1;
            pend_sym_next = e_sym;
            pend_fin_next = e_fin;
            pend_err_next = e_err;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_SIZE;
            hdr_idx_reg <= '0;
            rem_reg     <= '0;
            entries_reg <= '0;
            gbits_reg   <= '0;
            gcnt_reg    <= '0;
            esym_reg    <= '0;
            cbl_reg     <= '0;
            walk_reg    <= '0;
            nf_reg      <= NW'(1);
            cur_reg     <= '0;
            root_reg    <= '0;
            pend_v_reg  <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            rem_reg     <= rem_next;
            entries_reg <= entries_next;
            gbits_reg   <= gbits_next;
            gcnt_reg    <= gcnt_next;
            esym_reg    <= esym_next;
            cbl_reg     <= cbl_next;
            walk_reg    <= walk_next;
            nf_reg      <= nf_next;
            cur_reg     <= cur_next;
            root_reg    <= root_next;
            pend_v_reg  <= pend_v_next;
            out_v_reg   <= out_v_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        child_reg    <= child_next;
        shift_reg    <= shift_next;
        bcnt_reg     <= bcnt_next;
        pend_sym_reg <= pend_sym_next;
        pend_fin_reg <= pend_fin_next;
        pend_err_reg <= pend_err_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
        out_fin_reg  <= out_fin_next;
        out_err_reg  <= out_err_next;
    end

    // A new byte is taken only after the previous one has been closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_v_reg)
        else $error("input accepted with a result still staged");

    // Error words carry no symbol and no finished flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tuser[0]))
        else $error("error word with symbol or finished flag");

    // The allocator never runs past the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        nf_reg <= NODE_LIMIT)
        else $error("node allocation beyond table size");

    // A finished or error word ends the byte that caused it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[0] || m_tuser[1])) |-> m_tlast)
        else $error("terminal word without tlast");

endmodule
